// ===== rtl/alc_pkg.sv =====
// alc_pkg: widths, register codes and segment coefficient tables of the lux calculator
// no dependencies; imported by ambient_light_lux_calculator and alc_checker
`default_nettype none

package alc_pkg;

    localparam int CHAN_FRAC  = 10;
    localparam int RATIO_FRAC = 9;
    localparam int LUX_FRAC   = 14;
    localparam int SCALE_W    = 15;
    localparam int FACTOR_W   = SCALE_W + 4;
    localparam int QUOT_W     = RATIO_FRAC + 2;
    localparam int RATIO_W    = QUOT_W;
    localparam int COEF_W     = 10;
    localparam int SEGMENTS   = 7;
    localparam int COUNT_W    = 16;
    localparam int LUX_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [SCALE_W-1:0] SCALE_13MS  = 15'h7517;
    localparam logic [SCALE_W-1:0] SCALE_101MS = 15'h0fe7;
    localparam logic [SCALE_W-1:0] SCALE_UNITY = 15'h0400;

    localparam logic [LUX_W-1:0] LUX_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN  = 2'd0,
        REG_ITIME = 2'd1,
        REG_PKG   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ITIME_13MS   = 2'd0,
        ITIME_101MS  = 2'd1,
        ITIME_402MS  = 2'd2,
        ITIME_MANUAL = 2'd3
    } itime_t;

    localparam logic GAIN_1X  = 1'b0;
    localparam logic GAIN_16X = 1'b1;
    localparam logic PKG_T    = 1'b0;
    localparam logic PKG_CS   = 1'b1;

    typedef logic [SEGMENTS-1:0][RATIO_W-1:0] knee_vec_t;
    typedef logic [SEGMENTS-1:0][COEF_W-1:0]  coef_vec_t;

    typedef struct packed {
        logic [COEF_W-1:0] base;
        logic [COEF_W-1:0] slope;
    } coef_t;

    localparam knee_vec_t KNEE_T = {
        11'h29a, 11'h19a, 11'h138, 11'h100, 11'h0c0, 11'h080, 11'h040
    };
    localparam knee_vec_t KNEE_CS = {
        11'h29a, 11'h19a, 11'h14d, 11'h10a, 11'h0c8, 11'h085, 11'h043
    };
    localparam coef_vec_t BASE_T = {
        10'h018, 10'h0d2, 10'h16f, 10'h270, 10'h23f, 10'h214, 10'h1f2
    };
    localparam coef_vec_t BASE_CS = {
        10'h037, 10'h101, 10'h177, 10'h282, 10'h253, 10'h228, 10'h204
    };
    localparam coef_vec_t SLOPE_T = {
        10'h012, 10'h0fb, 10'h1fc, 10'h3fe, 10'h37b, 10'h2d1, 10'h1be
    };
    localparam coef_vec_t SLOPE_CS = {
        10'h02b, 10'h127, 10'h1dd, 10'h3df, 10'h363, 10'h2c1, 10'h1ad
    };

    // first segment whose knee is not below the ratio, zero past the last knee
    function automatic coef_t seg_lookup(input logic pkg, input logic [RATIO_W-1:0] ratio);
        coef_t     c;
        knee_vec_t knee;
        coef_vec_t base;
        coef_vec_t slope;
        c     = '0;
        knee  = (pkg == PKG_CS) ? KNEE_CS : KNEE_T;
        base  = (pkg == PKG_CS) ? BASE_CS : BASE_T;
        slope = (pkg == PKG_CS) ? SLOPE_CS : SLOPE_T;
        for (int s = SEGMENTS - 1; s >= 0; s--)
        begin
            if (ratio <= knee[s])
            begin
                c.base  = base[s];
                c.slope = slope[s];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ambient_light_lux_calculator.sv =====
// ambient_light_lux_calculator: pipelined lux computation from two photodiode counts
// depends on alc_pkg; checked by alc_checker (bound in its own file)
//
// Usage:
//   Input channel: broadband_count and infrared_count with in_valid; the block
//   raises in_stall to hold a request. Output channel: lux with out_valid; the
//   receiver raises out_stall to hold a result. A request moves at an edge where
//   valid is high and stall is low.
//   Configuration: cfg_index/cfg_data with cfg_valid, cfg_ready is always high.
//   Index 0 gain select, 1 integration time, 2 package type; other indexes are
//   ignored. Write only while no request is in flight.
//   Throughput: one request per cycle while out_stall stays low.
//   Stages: count scaling multiply, ratio overflow check, one quotient bit per
//   stage over 11 divider stages, segment lookup, coefficient multiply,
//   difference, rounding. The 11-stage restoring divider sets the depth.
//   Stall: each stage holds only while it is full and the stage after it holds,
//   so bubbles close up and new requests enter while a result waits at lux.
//   Reset: all valid bits clear, registers return to 16x gain, 402 ms, T package.
`default_nettype none

module ambient_light_lux_calculator #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire  [alc_pkg::COUNT_W-1:0]    broadband_count,
    input  wire  [alc_pkg::COUNT_W-1:0]    infrared_count,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [alc_pkg::LUX_W-1:0]      lux,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [alc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import alc_pkg::*;

    localparam int PRE_W   = SAMPLE_BITS + FACTOR_W;
    localparam int CH_W    = PRE_W - CHAN_FRAC;
    localparam int REM_W   = CH_W + QUOT_W;
    localparam int DIV_N   = QUOT_W;
    localparam int PROD_W  = CH_W + COEF_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int SH_W    = SUM_W - LUX_FRAC;
    localparam int EXT_W   = (SH_W > LUX_W) ? SH_W : LUX_W;
    localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (LUX_FRAC - 1);

    // configuration
    logic   gain_reg;
    itime_t itime_reg;
    logic   pkg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_16X;
            itime_reg <= ITIME_402MS;
            pkg_reg   <= PKG_T;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN:  gain_reg  <= cfg_data[0];
                REG_ITIME: itime_reg <= itime_t'(cfg_data);
                REG_PKG:   pkg_reg   <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // stage ready chain
    logic             s1_vld_reg;
    logic             dv_vld_reg [0:DIV_N];
    logic             lu_vld_reg;
    logic             mul_vld_reg;
    logic             dif_vld_reg;
    logic             out_vld_reg;
    logic             out_rdy;
    logic             dif_rdy;
    logic             mul_rdy;
    logic             lu_rdy;
    logic             dv_rdy [0:DIV_N];
    logic             s1_rdy;

    always_comb
    begin
        out_rdy = !out_vld_reg || !out_stall;
        dif_rdy = !dif_vld_reg || out_rdy;
        mul_rdy = !mul_vld_reg || dif_rdy;
        lu_rdy  = !lu_vld_reg || mul_rdy;
        dv_rdy[DIV_N] = !dv_vld_reg[DIV_N] || lu_rdy;
        for (int i = DIV_N - 1; i >= 0; i--)
        begin
            dv_rdy[i] = !dv_vld_reg[i] || dv_rdy[i + 1];
        end
        s1_rdy = !s1_vld_reg || dv_rdy[0];
    end

    assign in_stall = !s1_rdy;

    // stage 1: scale counts to 16x / 402 ms
    logic [SCALE_W-1:0]     scale;
    logic [FACTOR_W-1:0]    factor;
    logic [PRE_W-1:0]       pre0;
    logic [PRE_W-1:0]       pre1;
    logic [CH_W-1:0]        s1_c0_reg;
    logic [CH_W-1:0]        s1_c1_reg;

    always_comb
    begin
        case (itime_reg)
            ITIME_13MS:  scale = SCALE_13MS;
            ITIME_101MS: scale = SCALE_101MS;
            default:     scale = SCALE_UNITY;
        endcase
        factor = (gain_reg == GAIN_1X) ? {scale, 4'b0000} : FACTOR_W'(scale);
        pre0   = PRE_W'(broadband_count[SAMPLE_BITS-1:0]) * PRE_W'(factor);
        pre1   = PRE_W'(infrared_count[SAMPLE_BITS-1:0]) * PRE_W'(factor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (s1_rdy)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            s1_c0_reg <= pre0[PRE_W-1:CHAN_FRAC];
            s1_c1_reg <= pre1[PRE_W-1:CHAN_FRAC];
        end
    end

    // divider stages: index 0 sets up the remainder, 1..DIV_N each resolve one bit
    logic [CH_W-1:0]   dv_c0_reg   [0:DIV_N];
    logic [CH_W-1:0]   dv_c1_reg   [0:DIV_N];
    logic [QUOT_W-1:0] dv_q_reg    [0:DIV_N];
    logic              dv_zero_reg [0:DIV_N];
    logic              dv_ovf_reg  [0:DIV_N];
    logic [REM_W-1:0]  dv_rem_reg  [0:DIV_N-1];
    logic [REM_W-1:0]  div_trial   [1:DIV_N];
    logic              div_ge      [1:DIV_N];
    logic [REM_W-1:0]  dv_rem_next [1:DIV_N-1];
    logic [QUOT_W-1:0] dv_q_next   [1:DIV_N];

    always_comb
    begin
        for (int i = 1; i <= DIV_N; i++)
        begin
            div_trial[i] = REM_W'(dv_c0_reg[i - 1]) << (DIV_N - i);
            div_ge[i]    = dv_rem_reg[i - 1] >= div_trial[i];
            dv_q_next[i] = dv_q_reg[i - 1] | (QUOT_W'(div_ge[i]) << (DIV_N - i));
        end
        for (int i = 1; i < DIV_N; i++)
        begin
            dv_rem_next[i] = div_ge[i] ? dv_rem_reg[i - 1] - div_trial[i] : dv_rem_reg[i - 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_N; i++)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (dv_rdy[0])
                dv_vld_reg[0] <= s1_vld_reg;
            for (int i = 1; i <= DIV_N; i++)
            begin
                if (dv_rdy[i])
                    dv_vld_reg[i] <= dv_vld_reg[i - 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_rdy[0])
        begin
            dv_c0_reg[0]   <= s1_c0_reg;
            dv_c1_reg[0]   <= s1_c1_reg;
            dv_q_reg[0]    <= '0;
            dv_zero_reg[0] <= (s1_c0_reg == '0);
            // ratio of two or more lies past every knee
            dv_ovf_reg[0]  <= {1'b0, s1_c1_reg} >= {s1_c0_reg, 1'b0};
            dv_rem_reg[0]  <= REM_W'({s1_c1_reg, {(RATIO_FRAC + 1){1'b0}}});
        end
        for (int i = 1; i <= DIV_N; i++)
        begin
            if (dv_rdy[i])
            begin
                dv_c0_reg[i]   <= dv_c0_reg[i - 1];
                dv_c1_reg[i]   <= dv_c1_reg[i - 1];
                dv_q_reg[i]    <= dv_q_next[i];
                dv_zero_reg[i] <= dv_zero_reg[i - 1];
                dv_ovf_reg[i]  <= dv_ovf_reg[i - 1];
            end
        end
        for (int i = 1; i < DIV_N; i++)
        begin
            if (dv_rdy[i])
                dv_rem_reg[i] <= dv_rem_next[i];
        end
    end

    // segment lookup
    logic [QUOT_W:0]    ratio_sum;
    logic [RATIO_W-1:0] ratio;
    coef_t              coef_next;
    logic [CH_W-1:0]    lu_c0_reg;
    logic [CH_W-1:0]    lu_c1_reg;
    coef_t              lu_coef_reg;

    always_comb
    begin
        ratio_sum = {1'b0, dv_q_reg[DIV_N]} + (QUOT_W + 1)'(1);
        ratio     = ratio_sum[QUOT_W:1];
        if (dv_zero_reg[DIV_N])
            coef_next = seg_lookup(pkg_reg, '0);
        else if (dv_ovf_reg[DIV_N])
            coef_next = '0;
        else
            coef_next = seg_lookup(pkg_reg, ratio);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lu_vld_reg <= 1'b0;
        else if (lu_rdy)
            lu_vld_reg <= dv_vld_reg[DIV_N];
    end

    always_ff @(posedge clk)
    begin
        if (lu_rdy)
        begin
            lu_c0_reg   <= dv_c0_reg[DIV_N];
            lu_c1_reg   <= dv_c1_reg[DIV_N];
            lu_coef_reg <= coef_next;
        end
    end

    // coefficient products
    logic [PROD_W-1:0] pos_reg;
    logic [PROD_W-1:0] neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else if (mul_rdy)
            mul_vld_reg <= lu_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mul_rdy)
        begin
            pos_reg <= PROD_W'(lu_c0_reg) * PROD_W'(lu_coef_reg.base);
            neg_reg <= PROD_W'(lu_c1_reg) * PROD_W'(lu_coef_reg.slope);
        end
    end

    // difference with clamp flag
    logic [PROD_W-1:0] dif_reg;
    logic              clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dif_vld_reg <= 1'b0;
        else if (dif_rdy)
            dif_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (dif_rdy)
        begin
            dif_reg   <= pos_reg - neg_reg;
            clamp_reg <= neg_reg >= pos_reg;
        end
    end

    // rounding, shift and saturation into the output register
    logic [SUM_W-1:0] sum;
    logic [EXT_W-1:0] shifted;
    logic [LUX_W-1:0] lux_next;
    logic [LUX_W-1:0] lux_reg;

    always_comb
    begin
        sum     = {1'b0, dif_reg} + ROUND;
        shifted = EXT_W'(sum[SUM_W-1:LUX_FRAC]);
        if (clamp_reg)
            lux_next = '0;
        else if (shifted > EXT_W'(LUX_MAX))
            lux_next = LUX_MAX;
        else
            lux_next = shifted[LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_rdy)
            out_vld_reg <= dif_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
            lux_reg <= lux_next;
    end

    assign out_valid = out_vld_reg;
    assign lux       = lux_reg;

endmodule

`default_nettype wire

// ===== rtl/alc_checker.sv =====
// alc_checker: port-level assertions for ambient_light_lux_calculator
// depends on alc_pkg; bound to the top level at the end of this file
`default_nettype none

module alc_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_stall,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [alc_pkg::LUX_W-1:0]       lux,
    input wire                            cfg_valid,
    input wire                            cfg_ready
);
    import alc_pkg::*;

    // a held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("held result dropped");

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(lux))
        else $error("held result changed");

    // the input only backs up when a result is held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output is free");

    // configuration writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind ambient_light_lux_calculator alc_checker u_alc_checker (.*);

`default_nettype wire
